// ===== hdl/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Word types, token kind codes, character codes and keyword tables shared by
// the tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } stt_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        run_last;
  } stt_out_t;

  localparam int MAX_TOKENS = 3;

  typedef struct packed {
    logic [1:0]                     cnt;
    stt_out_t [MAX_TOKENS-1:0]      tok;
  } stt_bundle_t;

  localparam int          SOURCE_MAX = 65536;
  localparam logic [15:0] SAT_MAX    = 16'hFFFF;
  localparam int          POS_LIM_I  = (SOURCE_MAX - 1 > 65535) ? 65535 : SOURCE_MAX - 1;
  localparam logic [15:0] POS_LIMIT  = 16'(POS_LIM_I);

  localparam logic [5:0] K_UNKNOWN    = 6'd0;
  localparam logic [5:0] K_EOF        = 6'd1;
  localparam logic [5:0] K_LPAREN     = 6'd2;
  localparam logic [5:0] K_RPAREN     = 6'd3;
  localparam logic [5:0] K_LBRACE     = 6'd4;
  localparam logic [5:0] K_RBRACE     = 6'd5;
  localparam logic [5:0] K_LBRACKET   = 6'd6;
  localparam logic [5:0] K_RBRACKET   = 6'd7;
  localparam logic [5:0] K_SEMI       = 6'd8;
  localparam logic [5:0] K_COLON      = 6'd9;
  localparam logic [5:0] K_DOT        = 6'd10;
  localparam logic [5:0] K_COMMA      = 6'd11;
  localparam logic [5:0] K_PIPE       = 6'd12;
  localparam logic [5:0] K_AT         = 6'd13;
  localparam logic [5:0] K_DOLLAR     = 6'd14;
  localparam logic [5:0] K_CONFIG     = 6'd15;
  localparam logic [5:0] K_CARET      = 6'd16;
  localparam logic [5:0] K_RAISE      = 6'd17;
  localparam logic [5:0] K_TRANSITION = 6'd18;
  localparam logic [5:0] K_MINUS      = 6'd19;
  localparam logic [5:0] K_ROLLBACK   = 6'd20;
  localparam logic [5:0] K_LT         = 6'd21;
  localparam logic [5:0] K_RUN        = 6'd22;
  localparam logic [5:0] K_GT         = 6'd23;
  localparam logic [5:0] K_PLUS       = 6'd24;
  localparam logic [5:0] K_MUL        = 6'd25;
  localparam logic [5:0] K_DIV        = 6'd26;
  localparam logic [5:0] K_MOD        = 6'd27;
  localparam logic [5:0] K_IMM_ASSIGN = 6'd28;
  localparam logic [5:0] K_ASSIGN     = 6'd29;
  localparam logic [5:0] K_STRING     = 6'd30;
  localparam logic [5:0] K_NUMBER     = 6'd31;
  localparam logic [5:0] K_IDENT      = 6'd32;
  localparam logic [5:0] K_FIRST_KW   = 6'd33;
  localparam logic [5:0] K_THROW      = 6'd42;

  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int NUM_KW = 10;

  // Keywords packed with the first character in the low byte.
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'("tratS"), 48'("nruteR"), 48'("tinI"), 48'("fi"), 48'("esle"),
    48'("rof"), 48'("elihw"), 48'("yrt"), 48'("hctac"), 48'("worht")
  };
  localparam int KW_LEN [NUM_KW] = '{5, 6, 4, 2, 4, 3, 5, 3, 5, 5};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [5:0] char_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACKET;
      8'h5D:   k = K_RBRACKET;
      8'h3B:   k = K_SEMI;
      8'h3A:   k = K_COLON;
      8'h2E:   k = K_DOT;
      8'h2C:   k = K_COMMA;
      8'h7C:   k = K_PIPE;
      8'h40:   k = K_AT;
      8'h24:   k = K_DOLLAR;
      8'h21:   k = K_CONFIG;
      8'h5E:   k = K_CARET;
      8'h2B:   k = K_PLUS;
      8'h2F:   k = K_DIV;
      8'h25:   k = K_MOD;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] inc_sat(input logic [15:0] x, input logic [15:0] lim);
    return (x < lim) ? x + 16'd1 : x;
  endfunction

  function automatic stt_out_t make_tok(input logic [5:0] k, input logic [15:0] s,
                                        input logic [15:0] l, input logic [15:0] ln,
                                        input logic [15:0] col);
    stt_out_t t;
    t.token_kind    = k;
    t.start_offset  = s;
    t.lexeme_length = l;
    t.line_number   = ln;
    t.column_number = col;
    t.run_last      = 1'b0;
    return t;
  endfunction

endpackage

// ===== hdl/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: one source byte per input word, tokens out one per word.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while it has room and emits tokens
// with kind, start offset, length, line and column. A byte is registered on
// input, scanned from that register, and its tokens are registered in the output
// serializer before they leave. A byte may finish up to three tokens; the output
// serializer sends one token per cycle while out_stall is low, so a byte that
// yields several tokens holds input off until its last token is taken. Bytes that
// yield zero or one token sustain one byte per cycle while out_stall is low. After
// the final byte all scan state returns to its reset values.
module source_text_tokenizer #(
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  logic        in_vld_r;
  stt_in_t     in_r;
  logic        room, adv;
  stt_bundle_t bundle;

  assign in_stall = in_vld_r && !room;
  assign adv      = in_vld_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
  end

  stt_core #(.KMAX(KEYWORD_MAX_LEN)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_r),
    .adv     (adv),
    .bundle  (bundle)
  );

  stt_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .bundle    (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !room |=> in_vld_r)
    else $error("Pending input word was dropped.");

  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.final_byte |-> bundle.cnt != 2'd0)
    else $error("Final byte produced no end of file token.");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == K_EOF) |->
      out_data.run_last && (out_data.lexeme_length == 16'd0))
    else $error("End of file token is not last or has a length.");

endmodule

// ===== hdl/stt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scan core
// Holds the scan mode and counters and turns one source byte into a bundle of
// up to three tokens in a single pass.
// ----------------------------------------------------------------------------
module stt_core #(
  parameter int KMAX = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stt_pkg::stt_in_t    in_word,
  input  logic                adv,
  output stt_pkg::stt_bundle_t bundle
);
  import stt_pkg::*;

  localparam int PW   = 8 * KMAX;
  localparam int WL_W = $clog2(KMAX + 2);

  typedef enum logic [3:0] {
    M_IDLE, M_TILDE, M_MINUS, M_LT, M_GT, M_EQ, M_STAR, M_HASH,
    M_BLOCK, M_BLOCK_STAR, M_STRING, M_NUMBER, M_WORD
  } mode_t;

  mode_t             mode_r, m;
  logic [15:0]       start_r, pos_r, line_r, col_r, tlen_r;
  logic [PW-1:0]     wp_r, wp;
  logic [WL_W-1:0]   wl_r, wl;
  logic [15:0]       ts, pos, ln, col, tl;
  logic [1:0]        n;
  stt_out_t          res [MAX_TOKENS];
  logic              redo, go_fresh, hit;
  logic [5:0]        pk;
  logic [6:0]        fk;
  logic [7:0]        b;

  function automatic logic [5:0] word_kind(input logic [PW-1:0] p, input logic [WL_W-1:0] l);
    logic [5:0] k;
    k = K_IDENT;
    if (l <= WL_W'(KMAX)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if ((l == WL_W'(KW_LEN[i])) && (p == PW'(KW_TEXT[i]))) k = K_FIRST_KW + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [6:0] flush_of(input mode_t mm, input logic [5:0] wk);
    logic [6:0] r;
    unique case (mm)
      M_TILDE:  r = {1'b1, K_UNKNOWN};
      M_MINUS:  r = {1'b1, K_MINUS};
      M_LT:     r = {1'b1, K_LT};
      M_GT:     r = {1'b1, K_GT};
      M_EQ:     r = {1'b1, K_ASSIGN};
      M_STAR:   r = {1'b1, K_MUL};
      M_STRING: r = {1'b1, K_UNKNOWN};
      M_NUMBER: r = {1'b1, K_NUMBER};
      M_WORD:   r = {1'b1, wk};
      default:  r = {1'b0, K_UNKNOWN};
    endcase
    return r;
  endfunction

  always_comb begin
    b        = in_word.source_byte;
    m        = mode_r;
    ts       = start_r;
    pos      = pos_r;
    ln       = line_r;
    col      = col_r;
    tl       = tlen_r;
    wp       = wp_r;
    wl       = wl_r;
    n        = 2'd0;
    redo     = 1'b0;
    go_fresh = 1'b0;
    hit      = 1'b0;
    pk       = K_UNKNOWN;
    fk       = '0;
    for (int i = 0; i < MAX_TOKENS; i++) res[i] = '0;

    unique case (m)
      M_TILDE: if (b == CH_GT) begin hit = 1'b1; pk = K_RAISE; end
      M_MINUS: if (b == CH_GT) begin hit = 1'b1; pk = K_TRANSITION; end
      M_LT: begin
        if (b == CH_TILDE) begin hit = 1'b1; pk = K_CONFIG; end
        else if (b == CH_MINUS) begin hit = 1'b1; pk = K_THROW; end
        else if (b == CH_LT) begin hit = 1'b1; pk = K_ROLLBACK; end
      end
      M_GT: if (b == CH_GT) begin hit = 1'b1; pk = K_RUN; end
      M_EQ: if (b == CH_EQ) begin hit = 1'b1; pk = K_IMM_ASSIGN; end
      default: ;
    endcase

    unique case (m)
      M_TILDE, M_MINUS, M_LT, M_GT, M_EQ: begin
        if (hit) begin
          pos = inc_sat(pos, POS_LIMIT);
          col = inc_sat(col, SAT_MAX);
          tl  = inc_sat(tl, SAT_MAX);
          res[n] = make_tok(pk, ts, tl, ln, col);
          n = n + 2'd1;
          m = M_IDLE;
        end else begin
          redo = 1'b1;
        end
      end
      M_STAR: begin
        if (b == CH_STAR) begin
          pos = inc_sat(pos, POS_LIMIT);
          col = inc_sat(col, SAT_MAX);
          tl  = inc_sat(tl, SAT_MAX);
          m   = M_BLOCK;
        end else begin
          redo = 1'b1;
        end
      end
      M_HASH: begin
        if (b == CH_NEWLINE) begin
          m        = M_IDLE;
          go_fresh = 1'b1;
        end else begin
          pos = inc_sat(pos, POS_LIMIT);
          col = inc_sat(col, SAT_MAX);
          tl  = inc_sat(tl, SAT_MAX);
        end
      end
      M_BLOCK, M_BLOCK_STAR: begin
        pos = inc_sat(pos, POS_LIMIT);
        col = inc_sat(col, SAT_MAX);
        tl  = inc_sat(tl, SAT_MAX);
        if (m == M_BLOCK) begin
          if (b == CH_STAR) m = M_BLOCK_STAR;
        end else begin
          m = (b == CH_STAR) ? M_IDLE : M_BLOCK;
        end
      end
      M_STRING: begin
        if (b == CH_NEWLINE) ln = inc_sat(ln, SAT_MAX);
        pos = inc_sat(pos, POS_LIMIT);
        col = inc_sat(col, SAT_MAX);
        tl  = inc_sat(tl, SAT_MAX);
        if (b == CH_QUOTE) begin
          res[n] = make_tok(K_STRING, ts, tl, ln, col);
          n = n + 2'd1;
          m = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          pos = inc_sat(pos, POS_LIMIT);
          col = inc_sat(col, SAT_MAX);
          tl  = inc_sat(tl, SAT_MAX);
        end else begin
          redo = 1'b1;
        end
      end
      M_WORD: begin
        if (is_digit(b) || is_alpha(b)) begin
          pos = inc_sat(pos, POS_LIMIT);
          col = inc_sat(col, SAT_MAX);
          tl  = inc_sat(tl, SAT_MAX);
          for (int i = 0; i < KMAX; i++) begin
            if (wl == WL_W'(i)) wp[8*i +: 8] = b;
          end
          if (wl <= WL_W'(KMAX)) wl = wl + 1'b1;
        end else begin
          redo = 1'b1;
        end
      end
      default: begin
        m        = M_IDLE;
        go_fresh = 1'b1;
      end
    endcase

    if (redo) begin
      fk = flush_of(m, word_kind(wp, wl));
      if (fk[6]) begin
        res[n] = make_tok(fk[5:0], ts, tl, ln, col);
        n = n + 2'd1;
      end
      m        = M_IDLE;
      go_fresh = 1'b1;
    end

    if (go_fresh) begin
      ts  = pos;
      tl  = 16'd0;
      pos = inc_sat(pos, POS_LIMIT);
      col = inc_sat(col, SAT_MAX);
      tl  = inc_sat(tl, SAT_MAX);
      priority if (b == CH_TILDE) m = M_TILDE;
      else if (b == CH_MINUS) m = M_MINUS;
      else if (b == CH_LT) m = M_LT;
      else if (b == CH_GT) m = M_GT;
      else if (b == CH_EQ) m = M_EQ;
      else if (b == CH_STAR) m = M_STAR;
      else if (b == CH_HASH) m = M_HASH;
      else if (b == CH_QUOTE) m = M_STRING;
      else if (is_digit(b)) m = M_NUMBER;
      else if (is_alpha(b)) begin
        m  = M_WORD;
        wp = '0;
        wp[7:0] = b;
        wl = WL_W'(1);
      end else begin
        res[n] = make_tok(char_kind(b), ts, tl, ln, col);
        n = n + 2'd1;
      end
    end

    if (in_word.final_byte) begin
      fk = flush_of(m, word_kind(wp, wl));
      if (fk[6]) begin
        res[n] = make_tok(fk[5:0], ts, tl, ln, col);
        n = n + 2'd1;
      end
      res[n] = make_tok(K_EOF, pos, 16'd0, ln, col);
      n = n + 2'd1;
      m   = M_IDLE;
      ts  = 16'd0;
      pos = 16'd0;
      ln  = 16'd1;
      col = 16'd1;
      tl  = 16'd0;
      wp  = '0;
      wl  = '0;
    end

    for (int i = 0; i < MAX_TOKENS; i++) begin
      res[i].run_last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  always_comb begin
    bundle.cnt = n;
    for (int i = 0; i < MAX_TOKENS; i++) bundle.tok[i] = res[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      start_r <= 16'd0;
      pos_r   <= 16'd0;
      line_r  <= 16'd1;
      col_r   <= 16'd1;
      tlen_r  <= 16'd0;
      wp_r    <= '0;
      wl_r    <= '0;
    end else if (adv) begin
      mode_r  <= m;
      start_r <= ts;
      pos_r   <= pos;
      line_r  <= ln;
      col_r   <= col;
      tlen_r  <= tl;
      wp_r    <= wp;
      wl_r    <= wl;
    end
  end

endmodule

// ===== hdl/stt_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer output serializer
// Registers a bundle of tokens and hands them out one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module stt_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  stt_pkg::stt_bundle_t bundle,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stt_pkg::stt_out_t    out_data
);
  import stt_pkg::*;

  logic                      vld_r;
  logic [1:0]                idx_r, cnt_r;
  stt_out_t [MAX_TOKENS-1:0] tok_r;
  logic                      pop, last;

  assign pop       = vld_r && !out_stall;
  assign last      = (idx_r == cnt_r - 2'd1);
  assign room      = !vld_r || (pop && last);
  assign out_valid = vld_r;
  assign out_data  = tok_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
      cnt_r <= 2'd0;
    end else if (adv && (bundle.cnt != 2'd0)) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
      cnt_r <= bundle.cnt;
    end else if (pop) begin
      if (last) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (bundle.cnt != 2'd0)) tok_r <= bundle.tok;
  end

endmodule
